[src/skset_pkg.sv]
`default_nettype none
package skset_pkg;

	localparam int CAPACITY = 32;
	localparam int KEY_W    = 32;
	localparam int OCC_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;
	localparam logic [1:0] OP_LIST   = 2'd3;

	localparam logic [2:0] ST_DONE   = 3'd0;
	localparam logic [2:0] ST_DUP    = 3'd1;
	localparam logic [2:0] ST_ABSENT = 3'd2;
	localparam logic [2:0] ST_FULL   = 3'd3;
	localparam logic [2:0] ST_LISTED = 3'd4;
	localparam logic [2:0] ST_EMPTY  = 3'd5;

	localparam logic [1:0] MODE_HOLD   = 2'd0;
	localparam logic [1:0] MODE_INSERT = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;
	localparam logic [1:0] MODE_ROTATE = 2'd3;

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		logic [1:0] mode;
		key_t       key;
	} cell_ctl_t;

endpackage
`default_nettype wire

[src/skset_cell.sv]
`default_nettype none
module skset_cell (
	input  wire logic                  clk,
	input  wire skset_pkg::cell_ctl_t  ctl,
	input  wire logic                  valid,
	input  wire logic                  is_tail,
	input  wire logic                  left_lt,
	input  wire skset_pkg::key_t       left_key,
	input  wire skset_pkg::key_t       right_key,
	input  wire skset_pkg::key_t       head_key,
	output skset_pkg::key_t            key_q,
	output logic                       lt,
	output logic                       eq
);
	import skset_pkg::*;

	key_t key_d;

	assign lt = valid && (key_q < ctl.key);
	assign eq = valid && (key_q == ctl.key);

	always_comb begin
		key_d = key_q;
		case (ctl.mode)
			MODE_INSERT: begin
				if (!lt) begin
					key_d = left_lt ? ctl.key : left_key;
				end
			end
			MODE_REMOVE: begin
				if (!lt) begin
					key_d = right_key;
				end
			end
			MODE_ROTATE: begin
				key_d = is_tail ? head_key : right_key;
			end
			default: key_d = key_q;
		endcase
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

endmodule
`default_nettype wire

[src/sorted_key_set_core.sv]
// Insert, remove, search: one transfer per cycle unless stalled, result registered on accept.
// List: a bubble, then one key per cycle unless stalled, as many as the occupancy, from the
// rotating cell chain; no input is taken until the last key is out. Empty list: one result.
// Reset (arst_n low, asynchronous) empties the set and drops any pending result;
// key cells are not cleared.
`default_nettype none
module sorted_key_set_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // opcode[1:0], key[33:2], zero pad
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // found[0], key_out[32:1], zero pad
	output logic [2:0]       m_tuser,   // status[2:0]
	output logic             m_tlast
);
	import skset_pkg::*;

	logic [1:0]       in_op;
	key_t             in_key;
	cell_ctl_t        ctl;
	key_t             cell_key [CAPACITY];
	logic [CAPACITY-1:0] cell_lt;
	logic [CAPACITY-1:0] cell_eq;

	logic [OCC_W-1:0] occ_q;
	logic             listing_q;
	logic [IDX_W-1:0] list_cnt_q;
	logic             out_valid_q;
	logic [2:0]       out_status_q;
	logic             out_found_q;
	key_t             out_key_q;
	logic             out_last_q;

	logic load, acc, hit, full, list_last;

	assign in_op  = s_tdata[1:0];
	assign in_key = $signed(s_tdata[33:2]);

	assign load      = !out_valid_q || m_tready;
	assign s_tready  = !listing_q && load;
	assign acc       = s_tvalid && s_tready;
	assign hit       = |cell_eq;
	assign full      = (occ_q == OCC_W'(CAPACITY));
	assign list_last = (OCC_W'(list_cnt_q) == occ_q - OCC_W'(1));

	always_comb begin
		ctl.key  = in_key;
		ctl.mode = MODE_HOLD;
		if (acc) begin
			case (in_op)
				OP_INSERT: if (!hit && !full) ctl.mode = MODE_INSERT;
				OP_REMOVE: if (hit) ctl.mode = MODE_REMOVE;
				default:   ctl.mode = MODE_HOLD;
			endcase
		end else if (listing_q && load) begin
			ctl.mode = MODE_ROTATE;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic lft_lt;
		key_t lft_key;
		key_t rgt_key;
		if (i == 0) begin : g_head
			assign lft_lt  = 1'b1;
			assign lft_key = in_key;
		end else begin : g_mid
			assign lft_lt  = cell_lt[i-1];
			assign lft_key = cell_key[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign rgt_key = cell_key[i];
		end else begin : g_nxt
			assign rgt_key = cell_key[i+1];
		end
		skset_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.valid     (OCC_W'(i) < occ_q),
			.is_tail   (occ_q == OCC_W'(i + 1)),
			.left_lt   (lft_lt),
			.left_key  (lft_key),
			.right_key (rgt_key),
			.head_key  (cell_key[0]),
			.key_q     (cell_key[i]),
			.lt        (cell_lt[i]),
			.eq        (cell_eq[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			listing_q   <= 1'b0;
			list_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.mode == MODE_INSERT) occ_q <= occ_q + OCC_W'(1);
			if (ctl.mode == MODE_REMOVE) occ_q <= occ_q - OCC_W'(1);
			if (acc) begin
				out_valid_q <= !(in_op == OP_LIST && occ_q != '0);
				if (in_op == OP_LIST && occ_q != '0) begin
					listing_q  <= 1'b1;
					list_cnt_q <= '0;
				end
			end else if (listing_q && load) begin
				out_valid_q <= 1'b1;
				list_cnt_q  <= list_cnt_q + IDX_W'(1);
				if (list_last) listing_q <= 1'b0;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			out_found_q <= 1'b0;
			out_key_q   <= '0;
			out_last_q  <= 1'b1;
			case (in_op)
				OP_INSERT: out_status_q <= hit ? ST_DUP : (full ? ST_FULL : ST_DONE);
				OP_REMOVE: out_status_q <= hit ? ST_DONE : ST_ABSENT;
				OP_SEARCH: begin
					out_status_q <= ST_DONE;
					out_found_q  <= hit;
				end
				default: out_status_q <= ST_EMPTY;
			endcase
		end else if (listing_q && load) begin
			out_status_q <= ST_LISTED;
			out_found_q  <= 1'b0;
			out_key_q    <= cell_key[0];
			out_last_q   <= list_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_key_q, out_found_q};
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

endmodule
`default_nettype wire

[tb/sv/tb_sorted_key_set_core.sv]
`timescale 1ns / 1ps
module tb_sorted_key_set_core;
	import skset_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int POOL_SIZE   = 48;
	localparam int RANDOM_ITEMS = 140;

	typedef struct packed {
		logic [2:0] status;
		logic       found;
		key_t       key_out;
		logic       last;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	key_t    set_keys[$];
	result_t expected_q[$];
	key_t    key_pool[POOL_SIZE];

	int unsigned cycle_count = 0;
	int unsigned error_count = 0;
	int unsigned n_items     = 0;
	int unsigned n_results   = 0;
	int unsigned n_lists     = 0;
	int unsigned n_full      = 0;
	int unsigned peak_occ    = 0;
	int unsigned hold_req    = 0;
	bit          tx_idle_on  = 1'b1;
	bit          rx_idle_on  = 1'b1;

	sorted_key_set_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned gap_len();
		if ($urandom_range(0, 19) < 16)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, want,
			cycle_count);
	endtask

	// set update and expected results for one accepted transfer
	function automatic void apply_op(input logic [1:0] op, input key_t key);
		int      pos;
		bit      hit;
		result_t r;
		r = '{status: ST_DONE, found: 1'b0, key_out: '0, last: 1'b1};
		if (op == OP_LIST) begin
			n_lists++;
			if (set_keys.size() == 0) begin
				r.status = ST_EMPTY;
				expected_q.push_back(r);
			end else begin
				foreach (set_keys[i]) begin
					r.status  = ST_LISTED;
					r.key_out = set_keys[i];
					r.last    = (i == set_keys.size() - 1);
					expected_q.push_back(r);
				end
			end
		end else begin
			pos = 0;
			while (pos < set_keys.size() && set_keys[pos] < key)
				pos++;
			hit = (pos < set_keys.size()) && (set_keys[pos] == key);
			case (op)
				OP_INSERT: begin
					if (hit) begin
						r.status = ST_DUP;
					end else if (set_keys.size() >= CAPACITY) begin
						r.status = ST_FULL;
						n_full++;
					end else begin
						set_keys.insert(pos, key);
					end
				end
				OP_REMOVE: begin
					if (hit)
						set_keys.delete(pos);
					else
						r.status = ST_ABSENT;
				end
				default: begin
					r.found = hit;
				end
			endcase
			expected_q.push_back(r);
			if (set_keys.size() > peak_occ)
				peak_occ = set_keys.size();
		end
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(input logic [1:0] op, input key_t key);
		int unsigned gap;
		gap = (tx_idle_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, key, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_op(op, key);
		n_items++;
		@(negedge clk);
	endtask

	function automatic key_t pick_key(input int present_pct);
		if (set_keys.size() != 0 && $urandom_range(0, 99) < present_pct)
			return set_keys[$urandom_range(0, set_keys.size() - 1)];
		if ($urandom_range(0, 1) == 0)
			return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return key_t'($urandom());
	endfunction

	task automatic test_empty_set();
		send_item(OP_LIST, key_t'(32'h1234_5678));
		send_item(OP_SEARCH, '0);
		send_item(OP_REMOVE, key_t'(-5));
	endtask

	task automatic test_extreme_keys();
		key_t kmin;
		key_t kmax;
		kmin = key_t'(32'h8000_0000);
		kmax = key_t'(32'h7fff_ffff);
		send_item(OP_INSERT, kmin);
		send_item(OP_INSERT, kmax);
		send_item(OP_INSERT, '0);
		send_item(OP_INSERT, key_t'(-1));
		send_item(OP_INSERT, key_t'(1));
		send_item(OP_INSERT, kmax);
		send_item(OP_INSERT, key_t'(32'h5555_5555));
		send_item(OP_INSERT, key_t'(32'haaaa_aaaa));
		send_item(OP_SEARCH, kmin);
		send_item(OP_SEARCH, kmax);
		send_item(OP_SEARCH, key_t'(2));
		send_item(OP_LIST, '1);
		send_item(OP_REMOVE, kmax);
		send_item(OP_REMOVE, kmax);
		send_item(OP_REMOVE, kmin);
		send_item(OP_LIST, '0);
		send_item(OP_SEARCH, kmin);
	endtask

	task automatic test_full_store();
		key_t k;
		while (set_keys.size() < CAPACITY)
			send_item(OP_INSERT, key_t'($urandom()));
		send_item(OP_INSERT, key_t'($urandom()));
		send_item(OP_INSERT, set_keys[5]);
		send_item(OP_LIST, '0);
		send_item(OP_SEARCH, set_keys[0]);
		k = set_keys[CAPACITY - 1];
		send_item(OP_REMOVE, k);
		send_item(OP_INSERT, k);
		send_item(OP_INSERT, key_t'($urandom()));
		send_item(OP_LIST, '0);
		while (set_keys.size() > 3)
			send_item(OP_REMOVE, set_keys[$urandom_range(0, set_keys.size() - 1)]);
	endtask

	// receiver holds off while the sender streams; the block must fill and stall
	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		hold_req   = 300;
		for (int n = 0; n < 24; n++) begin
			case (n % 4)
				0: send_item(OP_INSERT, pick_key(20));
				1: send_item(OP_SEARCH, pick_key(60));
				2: send_item(OP_LIST, key_t'($urandom()));
				default: send_item(OP_REMOVE, pick_key(50));
			endcase
		end
		tx_idle_on = 1'b1;
	endtask

	task automatic test_random_mix();
		int unsigned r;
		int unsigned w_ins;
		int unsigned w_rem;
		int unsigned w_srch;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n < 50) begin
				w_ins = 60; w_rem = 10; w_srch = 20;
			end else if (n < 95) begin
				w_ins = 35; w_rem = 30; w_srch = 25;
			end else begin
				w_ins = 15; w_rem = 50; w_srch = 25;
			end
			tx_idle_on = !(n >= 50 && n < 75);
			rx_idle_on = !(n >= 50 && n < 75);
			r = $urandom_range(0, 99);
			if (r < w_ins)
				send_item(OP_INSERT, pick_key(15));
			else if (r < w_ins + w_rem)
				send_item(OP_REMOVE, pick_key(70));
			else if (r < w_ins + w_rem + w_srch)
				send_item(OP_SEARCH, pick_key(50));
			else
				send_item(OP_LIST, key_t'($urandom()));
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		int unsigned rx_stall;
		int unsigned rx_hold;
		rx_stall = 0;
		rx_hold  = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				rx_hold  = hold_req;
				hold_req = 0;
			end
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (rx_hold != 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if (rx_stall != 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				rx_stall = gap_len() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (expected_q.size() == 0) begin
				report_mismatch("result with none expected", {21'b0, m_tuser, m_tdata}, '0);
			end else begin
				want = expected_q.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", 64'(m_tuser), 64'(want.status));
				if (m_tdata[0] !== want.found)
					report_mismatch("found", 64'(m_tdata[0]), 64'(want.found));
				if (m_tdata[32:1] !== want.key_out)
					report_mismatch("key_out", 64'(m_tdata[32:1]),
						64'(unsigned'(want.key_out)));
				if (m_tlast !== want.last)
					report_mismatch("last", 64'(m_tlast), 64'(want.last));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			expected_q.size());
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		key_pool[0] = key_t'(32'h8000_0000);
		key_pool[1] = key_t'(32'h7fff_ffff);
		key_pool[2] = '0;
		key_pool[3] = key_t'(-1);
		key_pool[4] = key_t'(1);
		for (int i = 5; i < POOL_SIZE; i++)
			key_pool[i] = (i % 2 == 0) ? key_t'($urandom())
				: key_t'(int'($urandom_range(0, 200)) - 100);
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_set();
		test_extreme_keys();
		test_full_store();
		test_backpressure();
		test_random_mix();
		s_tvalid <= 1'b0;

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("run: %0d input transfers, %0d results checked, %0d list commands",
			n_items, n_results, n_lists);
		$display("peak occupancy %0d of %0d, %0d inserts refused on a full store",
			peak_occ, CAPACITY, n_full);
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", error_count);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

[sim.f]
src/skset_pkg.sv
src/skset_cell.sv
src/sorted_key_set_core.sv
tb/sv/tb_sorted_key_set_core.sv
